// ----- rtl/button_click_classifier_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the button click classifier
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// same-cycle implication, reset masked
`define BCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bcc_pkg.sv -----
// ---------------------------------------------------------------------------
// bcc_pkg
// Shared types and codes for the button click classifier.
// ---------------------------------------------------------------------------
package bcc_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_WIN   = 2'd2;

  localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd500;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd100;
  localparam logic [CFG_W-1:0] CLICK_WIN_RST  = 16'd40;

  // session phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_GAP     = 2'd2;

  // commands
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_UNLOCK = 2'd1;
  localparam logic [1:0] CMD_LOCK   = 2'd2;
  localparam logic [1:0] CMD_WINDOW = 2'd3;

  localparam logic [1:0] CLICK_MAX  = 2'd3;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] click_win;
  } cfg_t;

endpackage

// ----- rtl/bcc_cfg.sv -----
// ---------------------------------------------------------------------------
// bcc_cfg
// Configuration register file: three limit registers, write only.
// ---------------------------------------------------------------------------
module bcc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]     cfg_data,
  output bcc_pkg::cfg_t                 cfg
);

  bcc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::REG_TIMEOUT:    cfg_nxt.timeout    = cfg_data;
        bcc_pkg::REG_LONG_PRESS: cfg_nxt.long_press = cfg_data;
        bcc_pkg::REG_CLICK_WIN:  cfg_nxt.click_win  = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout    <= bcc_pkg::TIMEOUT_RST;
      cfg_r.long_press <= bcc_pkg::LONG_PRESS_RST;
      cfg_r.click_win  <= bcc_pkg::CLICK_WIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/bcc_core.sv -----
// ---------------------------------------------------------------------------
// bcc_core
// Session state and the per-item update: phase, timers, click count.
// ---------------------------------------------------------------------------
module bcc_core #(
  parameter int TIMER_BITS = bcc_pkg::TIMER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic          kind,
  input  logic          down,
  input  bcc_pkg::cfg_t cfg,
  output logic          res_valid,
  output logic [1:0]    res_cmd
);

  localparam int CW = (TIMER_BITS > bcc_pkg::CFG_W) ? TIMER_BITS : bcc_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic [1:0]            phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0] ptimer_r, ptimer_nxt;
  logic [1:0]            clicks_r, clicks_nxt;
  logic                  done;

  function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] v);
    bump = (v == TMAX) ? v : v + 1'b1;
  endfunction

  // a limit wider than the counter acts as the counter maximum
  function automatic logic reached(input logic [TIMER_BITS-1:0] v,
                                   input logic [bcc_pkg::CFG_W-1:0] lim);
    reached = (CW'(v) >= CW'(lim)) || (v == TMAX);
  endfunction

  function automatic logic [1:0] decide(input logic [1:0] c);
    if (c >= bcc_pkg::CLICK_MAX)
      decide = bcc_pkg::CMD_WINDOW;
    else if (c != 2'd0)
      decide = bcc_pkg::CMD_UNLOCK;
    else
      decide = bcc_pkg::CMD_NONE;
  endfunction

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    ptimer_nxt  = ptimer_r;
    clicks_nxt  = clicks_r;
    res_valid   = 1'b0;
    res_cmd     = bcc_pkg::CMD_NONE;
    done        = 1'b0;
    if (fire) begin
      if (kind == bcc_pkg::KIND_START) begin
        elapsed_nxt = '0;
        ptimer_nxt  = '0;
        clicks_nxt  = '0;
        if (!down) begin
          phase_nxt = bcc_pkg::PH_IDLE;
          res_valid = 1'b1;
          res_cmd   = bcc_pkg::CMD_UNLOCK;
        end else begin
          phase_nxt = bcc_pkg::PH_PRESSED;
        end
      end else if (phase_r == bcc_pkg::PH_PRESSED || phase_r == bcc_pkg::PH_GAP) begin
        elapsed_nxt = bump(elapsed_r);
        ptimer_nxt  = bump(ptimer_r);
        if (phase_r == bcc_pkg::PH_PRESSED) begin
          if (!down) begin
            if (clicks_r < bcc_pkg::CLICK_MAX)
              clicks_nxt = clicks_r + 2'd1;
            phase_nxt  = bcc_pkg::PH_GAP;
            ptimer_nxt = '0;
          end else if (reached(ptimer_nxt, cfg.long_press)) begin
            phase_nxt = bcc_pkg::PH_IDLE;
            res_valid = 1'b1;
            res_cmd   = bcc_pkg::CMD_LOCK;
            done      = 1'b1;
          end
        end else begin
          if (down) begin
            phase_nxt  = bcc_pkg::PH_PRESSED;
            ptimer_nxt = '0;
          end else if (reached(ptimer_nxt, cfg.click_win)) begin
            phase_nxt = bcc_pkg::PH_IDLE;
            res_valid = 1'b1;
            res_cmd   = decide(clicks_nxt);
            done      = 1'b1;
          end
        end
        // overall timeout, only if the session is still open
        if (!done && reached(elapsed_nxt, cfg.timeout)) begin
          phase_nxt = bcc_pkg::PH_IDLE;
          res_valid = 1'b1;
          res_cmd   = decide(clicks_nxt);
        end
      end else begin
        phase_nxt = bcc_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= bcc_pkg::PH_IDLE;
      elapsed_r <= '0;
      ptimer_r  <= '0;
      clicks_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      ptimer_r  <= ptimer_nxt;
      clicks_r  <= clicks_nxt;
    end
  end

endmodule

// ----- rtl/button_click_classifier.sv -----
// Flow: an accepted item is held in the input register until the result
//   register can take a result; its command, if any, is then registered there.
// Throughput: one item per cycle when not stalled; the session update is one
//   pass of counters and compares between the input and result registers.
// Reset (rst_n low, synchronous): session idle, timers and clicks cleared,
//   no item held, limits back to 500 / 100 / 40 ticks.
// ---------------------------------------------------------------------------
// button_click_classifier
// Turns button samples into unlock, lock, window or none commands; a timeout also ends a session.
// ---------------------------------------------------------------------------
module button_click_classifier #(
  parameter int TIMER_BITS = bcc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic                          in_button_down,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_command,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]     cfg_data
);

  bcc_pkg::cfg_t cfg;

  logic       in_vld_r, in_vld_nxt;
  logic       kind_r, down_r;
  logic       out_vld_r, out_vld_nxt;
  logic [1:0] out_cmd_r, out_cmd_nxt;
  logic       accept, advance;
  logic       res_valid;
  logic [1:0] res_cmd;

  // the held item moves on whenever the result register can take a result
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign accept   = in_valid && !in_stall;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .kind      (kind_r),
    .down      (down_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_cmd   (res_cmd)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept)
      in_vld_nxt = 1'b1;
    else if (advance)
      in_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    out_cmd_nxt = out_cmd_r;
    if (advance && res_valid) begin
      out_vld_nxt = 1'b1;
      out_cmd_nxt = res_cmd;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      down_r <= in_button_down;
    end
    out_cmd_r <= out_cmd_nxt;
  end

  assign out_valid   = out_vld_r;
  assign out_command = out_cmd_r;

endmodule

// ----- rtl/bcc_checker.sv -----
// ---------------------------------------------------------------------------
// bcc_checker
// Port-level checks for the button click classifier.
// ---------------------------------------------------------------------------
`include "button_click_classifier_macros.svh"

module bcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_kind,
  input logic       in_button_down,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_command
);

  logic start_up;
  logic out_held;
  logic out_free;
  logic out_unlock;

  assign start_up = in_valid && !in_stall && (in_kind == bcc_pkg::KIND_START)
                    && !in_button_down;
  assign out_held   = out_valid && out_stall;
  assign out_free   = !out_valid || !out_stall;
  assign out_unlock = out_valid && (out_command == bcc_pkg::CMD_UNLOCK);

  // result held while the consumer stalls
  `BCC_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_command), "result changed")

  // input only backs up behind a stalled, full result register
  `BCC_ASSERT_SAME(a_stall_cause, in_stall, out_held, "input stalled with no backpressure")

  // a start with the button up answers unlock once the result register is free
  `BCC_ASSERT_NEXT(a_start_unlock, start_up ##1 out_free, out_unlock, "no unlock after start")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
